// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Every check runs on the rising clock edge and is held off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on clk_i and disabled in reset.
`define CLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, for a property that must hold in the cycle after its trigger.
`define CLE_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/core/cle_pkg.sv -----
package cle_pkg;

  // Line store geometry.
  localparam int LineBuffer = 64;
  localparam int PtrW       = $clog2(LineBuffer);
  localparam int LenW       = $clog2(LineBuffer + 1);

  // Configuration port geometry.
  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  // Register map, by word index.
  typedef enum logic [2:0] {
    RegErase = 3'd0,
    RegKill  = 3'd1,
    RegEof   = 3'd2,
    RegEol   = 3'd3,
    RegUpper = 3'd4,
    RegExt   = 3'd5
  } reg_idx_e;

  // Reason a line ended, as carried on the last beat of a line.
  typedef enum logic [1:0] {
    CauseMid       = 2'd0,
    CauseLine      = 2'd1,
    CauseEof       = 2'd2,
    CauseExhausted = 2'd3
  } cause_e;

  // What the item under work asks of the controller.
  typedef enum logic [1:0] {
    PlanNone   = 2'd0,
    PlanSingle = 2'd1,
    PlanStream = 2'd2
  } plan_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StProc   = 2'd1,
    StFetch  = 2'd2,
    StStream = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] eof_char;
    logic [7:0] eol_char;
    logic       upper_case_mode;
    logic       external_processing;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic commit;
    logic load_single;
    logic load_stream;
    logic rd_start;
    logic rd_next;
  } cmd_t;

  typedef struct packed {
    plan_e plan;
    logic  out_free;
    logic  last_byte;
  } status_t;

endpackage

// ----- rtl/core/cle_regs.sv -----
module cle_regs import cle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode; words outside the map are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegErase: cfg_d.erase_char          = pwdata[7:0];
        RegKill:  cfg_d.kill_char           = pwdata[7:0];
        RegEof:   cfg_d.eof_char            = pwdata[7:0];
        RegEol:   cfg_d.eol_char            = pwdata[7:0];
        RegUpper: cfg_d.upper_case_mode     = pwdata[0];
        RegExt:   cfg_d.external_processing = pwdata[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.erase_char          <= 8'd35;
      cfg_q.kill_char           <= 8'd64;
      cfg_q.eof_char            <= 8'd4;
      cfg_q.eol_char            <= 8'd0;
      cfg_q.upper_case_mode     <= 1'b0;
      cfg_q.external_processing <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode, zero extended.
  always_comb begin
    prdata = '0;
    unique case (idx)
      RegErase: prdata = {{(PdataW-8){1'b0}}, cfg_q.erase_char};
      RegKill:  prdata = {{(PdataW-8){1'b0}}, cfg_q.kill_char};
      RegEof:   prdata = {{(PdataW-8){1'b0}}, cfg_q.eof_char};
      RegEol:   prdata = {{(PdataW-8){1'b0}}, cfg_q.eol_char};
      RegUpper: prdata = {{(PdataW-1){1'b0}}, cfg_q.upper_case_mode};
      RegExt:   prdata = {{(PdataW-1){1'b0}}, cfg_q.external_processing};
      default:  prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/cle_ctrl.sv -----
module cle_ctrl import cle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StProc;
      end
      StProc: begin
        unique case (status_i.plan)
          PlanNone:   state_d = StIdle;
          PlanSingle: if (status_i.out_free) state_d = StIdle;
          PlanStream: state_d = StFetch;
          default:    state_d = StIdle;
        endcase
      end
      StFetch: begin
        state_d = StStream;
      end
      StStream: begin
        if (status_i.out_free && status_i.last_byte) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o        = 1'b1;
        cmd_o.load_item   = in_valid_i;
      end
      StProc: begin
        unique case (status_i.plan)
          PlanNone:   cmd_o.commit = 1'b1;
          PlanSingle: begin
            cmd_o.commit      = status_i.out_free;
            cmd_o.load_single = status_i.out_free;
          end
          PlanStream: cmd_o.commit = 1'b1;
          default:    cmd_o.commit = 1'b0;
        endcase
      end
      StFetch: begin
        cmd_o.rd_start = 1'b1;
      end
      StStream: begin
        cmd_o.load_stream = status_i.out_free;
        cmd_o.rd_next     = status_i.out_free && !status_i.last_byte;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/cle_datapath.sv -----
module cle_datapath import cle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic       mode_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       last_o,
  output logic [1:0] end_cause_o
);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;

  // Upper-case table for escaped characters; zero means no entry.
  function automatic logic [7:0] case_map(input logic [7:0] c);
    logic [7:0] m;
    m = 8'h00;
    if (c >= 8'h61 && c <= 8'h7A) begin
      m = c - 8'h20;
    end else begin
      case (c)
        8'h21:   m = 8'h7C;  // '!' to '|'
        8'h27:   m = 8'h60;  // quote to backquote
        8'h28:   m = 8'h7B;  // '(' to '{'
        8'h29:   m = 8'h7D;  // ')' to '}'
        8'h5E:   m = 8'h7E;  // '^' to '~'
        default: m = 8'h00;
      endcase
    end
    return m;
  endfunction

  // Item under work, line state and the line store.
  logic             mode_q;
  logic [7:0]       byte_q;
  logic [PtrW-1:0]  fill_q, fill_d;
  logic             esc_q, esc_d;
  logic [LenW-1:0]  len_q;
  cause_e           cause_q;
  logic [7:0]       mem [LineBuffer];
  logic [7:0]       rd_data_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [PtrW-1:0]  rd_addr;

  // Output register.
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_has_q;
  logic             out_last_q;
  cause_e           out_cause_q;

  // Edit decision for the item under work.
  logic            do_sb, do_st, do_kill, do_eof, set_esc;
  logic [7:0]      st_byte, mapped;
  logic [PtrW-1:0] f1;
  logic [LenW-1:0] f_inc;
  logic            st_term, plain_emit, emit;
  logic [LenW-1:0] emit_n;
  cause_e          emit_cause;

  // Single-beat result (pass-through byte or empty-line marker).
  logic [7:0] sgl_byte;
  logic       sgl_has;
  logic       sgl_last;
  cause_e     sgl_cause;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= mode_i;
      byte_q <= in_byte_i;
    end
  end

  // Decode the byte against the editing characters and the escape flag.
  always_comb begin
    do_sb   = 1'b0;
    do_st   = 1'b0;
    do_kill = 1'b0;
    do_eof  = 1'b0;
    set_esc = 1'b0;
    st_byte = byte_q;
    mapped  = case_map(byte_q);
    if (!mode_q) begin
      if (!esc_q) begin
        if (byte_q == ChBackslash) begin
          set_esc = 1'b1;
          do_st   = 1'b1;
        end else if (byte_q == cfg_i.erase_char) begin
          do_sb = 1'b1;
        end else if (byte_q == cfg_i.kill_char) begin
          do_kill = 1'b1;
        end else if (byte_q == cfg_i.eof_char) begin
          do_eof = 1'b1;
        end else begin
          do_st = 1'b1;
        end
      end else begin
        if (byte_q == cfg_i.erase_char || byte_q == cfg_i.kill_char ||
            byte_q == cfg_i.eof_char) begin
          do_sb = 1'b1;
          do_st = 1'b1;
        end else if (cfg_i.upper_case_mode) begin
          if (mapped != 8'h00) begin
            do_sb   = 1'b1;
            do_st   = 1'b1;
            st_byte = mapped;
          end else if (byte_q != ChBackslash) begin
            do_st = 1'b1;
          end
        end else begin
          set_esc = (byte_q == ChBackslash);
          do_st   = 1'b1;
        end
      end
    end
  end

  // Store position, line end and the next fill count.
  always_comb begin
    f1 = fill_q;
    if (do_sb && fill_q != '0) f1 = fill_q - PtrW'(1);
    f_inc      = {1'b0, f1} + LenW'(1);
    st_term    = do_st && (st_byte == ChNewline || st_byte == cfg_i.eol_char);
    plain_emit = mode_q || do_eof;
    emit       = st_term || plain_emit;
    emit_n     = st_term ? f_inc : {1'b0, fill_q};
    if (st_term) begin
      emit_cause = CauseLine;
    end else if (mode_q) begin
      emit_cause = CauseExhausted;
    end else begin
      emit_cause = CauseEof;
    end

    if (emit || do_kill) begin
      fill_d = '0;
    end else if (do_st) begin
      fill_d = (f_inc == LenW'(LineBuffer)) ? f1 : f_inc[PtrW-1:0];
    end else begin
      fill_d = f1;
    end
    esc_d = emit ? 1'b0 : set_esc;
  end

  // Single-beat result and the status handed to the controller.
  always_comb begin
    sgl_byte  = 8'h00;
    sgl_has   = 1'b0;
    sgl_last  = 1'b1;
    sgl_cause = emit_cause;
    if (cfg_i.external_processing) begin
      if (mode_q) begin
        sgl_cause = CauseExhausted;
      end else if (byte_q == cfg_i.eof_char) begin
        sgl_cause = CauseEof;
      end else if (byte_q == ChNewline || byte_q == cfg_i.eol_char) begin
        sgl_byte  = byte_q;
        sgl_has   = 1'b1;
        sgl_cause = CauseLine;
      end else begin
        sgl_byte  = byte_q;
        sgl_has   = 1'b1;
        sgl_last  = 1'b0;
        sgl_cause = CauseMid;
      end
    end

    if (cfg_i.external_processing) begin
      status_o.plan = PlanSingle;
    end else if (emit) begin
      status_o.plan = (emit_n == '0) ? PlanSingle : PlanStream;
    end else begin
      status_o.plan = PlanNone;
    end
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.last_byte = ({1'b0, rd_ptr_q} + LenW'(1)) == len_q;
  end

  // Line state update; pass-through mode leaves the line alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      esc_q   <= 1'b0;
      len_q   <= '0;
      cause_q <= CauseMid;
    end else if (cmd_i.commit && !cfg_i.external_processing) begin
      fill_q <= fill_d;
      esc_q  <= esc_d;
      if (emit) begin
        len_q   <= emit_n;
        cause_q <= emit_cause;
      end
    end
  end

  // Line store: one write port, one registered read port.
  assign rd_addr = cmd_i.rd_start ? '0 : rd_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !cfg_i.external_processing && do_st) begin
      mem[f1] <= st_byte;
    end
    if (cmd_i.rd_start || cmd_i.rd_next) begin
      rd_data_q <= mem[rd_addr];
      rd_ptr_q  <= rd_addr;
    end
  end

  // Output register, freed when the downstream side takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_stream) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      out_byte_q  <= sgl_byte;
      out_has_q   <= sgl_has;
      out_last_q  <= sgl_last;
      out_cause_q <= sgl_cause;
    end else if (cmd_i.load_stream) begin
      out_byte_q  <= rd_data_q;
      out_has_q   <= 1'b1;
      out_last_q  <= status_o.last_byte;
      out_cause_q <= status_o.last_byte ? cause_q : CauseMid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign has_byte_o  = out_has_q;
  assign last_o      = out_last_q;
  assign end_cause_o = out_cause_q;

endmodule

// ----- rtl/core/canonical_line_editor.sv -----
// A byte that only edits the line is accepted in StIdle and decided in StProc;
// a single-beat result is loaded from StProc once the output register is free,
// and a finished line goes through StFetch, then streams one byte per cycle from
// the store while the output register is free. A new item is taken only when the
// last one is done, and a stalled output register holds the item until it frees.
// Reset (rst_ni, asynchronous, active low) clears the line, the escape flag,
// the output beat and restores the default editing characters.
`include "assert_macros.svh"

module canonical_line_editor import cle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic              last_o,
  output logic [1:0]        end_cause_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  cle_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cle_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (mode_i),
    .in_byte_i   (in_byte_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .last_o      (last_o),
    .end_cause_o (end_cause_o)
  );

  // An accepted item keeps the input side closed while it is decided.
  `CLE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  // A result beat is only loaded when the output register can take it.
  `CLE_ASSERT(a_load_when_free, !(cmd.load_single || cmd.load_stream) || status.out_free, "beat overwritten")
  // Loading a single beat, loading a stream beat and fetching the line never collide.
  `CLE_ASSERT(a_cmd_exclusive, $onehot0({cmd.load_single, cmd.load_stream, cmd.rd_start}), "command clash")

endmodule
